>>> sv/assert_macros.svh
// Shared assertion macros for the converter checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed while running");

// Check a property on every clock edge, reset included.
`define ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed around reset");

`endif

>>> sv/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Field widths.
  localparam int unsigned HueW    = 15;
  localparam int unsigned PctW    = 7;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned FoldW   = 12;
  localparam int unsigned ProdW   = 14;
  localparam int unsigned NumW    = 26;
  localparam int unsigned ScaledW = 18;
  localparam int unsigned RecipW  = 19;

  // Percent ceiling and hue geometry (1/64 degree units).
  localparam logic [PctW-1:0] PctMax     = 7'd100;
  localparam logic [HueW-1:0] HueSector  = 15'd3840;
  localparam logic [HueW-1:0] HuePair    = 15'd7680;
  localparam logic [NumW-1:0] SectorMul  = 26'd3840;
  localparam logic [NumW-1:0] FullMul    = 26'd384000;

  // 255/38400000 = 17/(4096*625): multiply by 17, drop 12 bits,
  // then divide by 625 through a reciprocal exact for all scaled values.
  localparam int unsigned     PreShift   = 12;
  localparam logic [RecipW-1:0] Recip    = 19'd429497;
  localparam int unsigned     RecipShift = 28;
  localparam logic [ChanW-1:0] ChanMax   = 8'd255;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  typedef struct packed {
    sector_t          sector;
    logic [FoldW-1:0] fold;
    logic [PctW-1:0]  sat;
    logic [PctW-1:0]  val;
  } prep_t;

  typedef struct packed {
    logic [ScaledW-1:0] r;
    logic [ScaledW-1:0] g;
    logic [ScaledW-1:0] b;
  } scaled_t;

  // floor(17 * num / 4096)
  function automatic logic [ScaledW-1:0] pre_scale(input logic [NumW-1:0] num);
    logic [NumW+4:0] p;
    p = {num, 4'b0000} + (NumW+5)'(num);
    return p[ScaledW+PreShift-1:PreShift];
  endfunction

endpackage

>>> sv/hsv_to_rgb_converter.sv
// Pipeline: a request reaches the outputs through 5 register stages.
// Throughput: one request per cycle unless the output stalls; each stage moves on whenever
// the next has room, so a stalled output backs up the pipe one stage at a time without loss.
// Reset: synchronous rst clears every valid bit; payload registers keep stale data.
// No clearing pass: the block takes requests in the first cycle after reset.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [HueW-1:0]  hue,
  input  logic [PctW-1:0]  saturation,
  input  logic [PctW-1:0]  brightness,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ChanW-1:0] red,
  output logic [ChanW-1:0] green,
  output logic [ChanW-1:0] blue
);

  logic    prep_valid;
  logic    prep_ready;
  prep_t   prep_data;
  logic    mix_valid;
  logic    mix_ready;
  scaled_t mix_data;

  // Clamp, sector and hue fold.
  hsv2rgb_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (prep_valid),
    .out_ready  (prep_ready),
    .out_data   (prep_data)
  );

  // Channel numerators and prescale.
  hsv2rgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_data  (mix_data)
  );

  // Final divide and output register.
  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

>>> sv/hsv2rgb_prep.sv
module hsv2rgb_prep import hsv2rgb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [HueW-1:0] hue,
  input  logic [PctW-1:0] saturation,
  input  logic [PctW-1:0] brightness,
  output logic            out_valid,
  input  logic            out_ready,
  output prep_t           out_data
);

  localparam logic [HueW-1:0] Edge2 = HueW'(HueSector * 2);
  localparam logic [HueW-1:0] Edge3 = HueW'(HueSector * 3);
  localparam logic [HueW-1:0] Edge4 = HueW'(HueSector * 4);
  localparam logic [HueW-1:0] Edge5 = HueW'(HueSector * 5);
  localparam logic [HueW-1:0] Pair2 = HueW'(HuePair * 2);
  localparam logic [HueW-1:0] Pair3 = HueW'(HuePair * 3);
  localparam logic [HueW-1:0] Pair4 = HueW'(HuePair * 4);

  logic [HueW-1:0] t;
  logic [HueW-1:0] fold_wide;
  prep_t           data_next;

  // Clamp percentages, pick the sector, fold hue into the 0..3840 ramp.
  always_comb begin
    data_next.sat = (saturation > PctMax) ? PctMax : saturation;
    data_next.val = (brightness > PctMax) ? PctMax : brightness;

    if (hue < HueSector) begin
      data_next.sector = SEC_RED_YEL;
    end else if (hue < Edge2) begin
      data_next.sector = SEC_YEL_GRN;
    end else if (hue < Edge3) begin
      data_next.sector = SEC_GRN_CYN;
    end else if (hue < Edge4) begin
      data_next.sector = SEC_CYN_BLU;
    end else if (hue < Edge5) begin
      data_next.sector = SEC_BLU_MAG;
    end else begin
      data_next.sector = SEC_MAG_RED;
    end

    if (hue >= Pair4) begin
      t = hue - Pair4;
    end else if (hue >= Pair3) begin
      t = hue - Pair3;
    end else if (hue >= Pair2) begin
      t = hue - Pair2;
    end else if (hue >= HuePair) begin
      t = hue - HuePair;
    end else begin
      t = hue;
    end

    fold_wide = (t >= HueSector) ? (HuePair - t) : t;
    data_next.fold = fold_wide[FoldW-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  // Advance the stage when downstream can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

>>> sv/hsv2rgb_mix.sv
module hsv2rgb_mix import hsv2rgb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  prep_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output scaled_t out_data
);

  // Stage A registers
  logic             va;
  logic [ProdW-1:0] sv_a;
  logic [ProdW-1:0] vm_a;
  logic [PctW-1:0]  val_a;
  logic [FoldW-1:0] fold_a;
  sector_t          sector_a;

  // Stage B registers
  logic            vb;
  logic [NumW-1:0] xs_b;
  logic [NumW-1:0] mm_b;
  logic [NumW-1:0] cm_b;
  sector_t         sector_b;

  logic rdy_a;
  logic rdy_b;
  logic rdy_c;

  logic [PctW-1:0] sat_inv;
  logic [NumW-1:0] xm;
  logic [NumW-1:0] num_r;
  logic [NumW-1:0] num_g;
  logic [NumW-1:0] num_b;
  scaled_t         data_next;

  assign rdy_c    = !out_valid || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  assign sat_inv = PctMax - in_data.sat;

  // Advance valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= in_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
      if (rdy_c) begin
        out_valid <= vb;
      end
    end
  end

  // Stage A: s*v and v*(100-s).
  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      sv_a     <= ProdW'(in_data.sat) * ProdW'(in_data.val);
      vm_a     <= ProdW'(in_data.val) * ProdW'(sat_inv);
      val_a    <= in_data.val;
      fold_a   <= in_data.fold;
      sector_a <= in_data.sector;
    end
  end

  // Stage B: ramp product, offset m and peak C+m over the common denominator.
  always_ff @(posedge clk) begin
    if (va && rdy_b) begin
      xs_b     <= NumW'(sv_a) * NumW'(fold_a);
      mm_b     <= NumW'(vm_a) * SectorMul;
      cm_b     <= NumW'(val_a) * FullMul;
      sector_b <= sector_a;
    end
  end

  // Stage C: route per sector and prescale.
  always_comb begin
    xm = xs_b + mm_b;
    case (sector_b)
      SEC_RED_YEL: begin num_r = cm_b; num_g = xm;   num_b = mm_b; end
      SEC_YEL_GRN: begin num_r = xm;   num_g = cm_b; num_b = mm_b; end
      SEC_GRN_CYN: begin num_r = mm_b; num_g = cm_b; num_b = xm;   end
      SEC_CYN_BLU: begin num_r = mm_b; num_g = xm;   num_b = cm_b; end
      SEC_BLU_MAG: begin num_r = xm;   num_g = mm_b; num_b = cm_b; end
      default:     begin num_r = cm_b; num_g = mm_b; num_b = xm;   end
    endcase
    data_next.r = pre_scale(num_r);
    data_next.g = pre_scale(num_g);
    data_next.b = pre_scale(num_b);
  end

  always_ff @(posedge clk) begin
    if (vb && rdy_c) begin
      out_data <= data_next;
    end
  end

endmodule

>>> sv/hsv2rgb_scale.sv
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  scaled_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ChanW-1:0] red,
  output logic [ChanW-1:0] green,
  output logic [ChanW-1:0] blue
);

  localparam int unsigned MulW = ScaledW + RecipW;
  localparam int unsigned QW   = MulW - RecipShift;

  logic [MulW-1:0] prod_r;
  logic [MulW-1:0] prod_g;
  logic [MulW-1:0] prod_b;
  logic [QW-1:0]   q_r;
  logic [QW-1:0]   q_g;
  logic [QW-1:0]   q_b;

  // Divide by 625 through the reciprocal, saturate to a byte.
  assign prod_r = MulW'(in_data.r) * MulW'(Recip);
  assign prod_g = MulW'(in_data.g) * MulW'(Recip);
  assign prod_b = MulW'(in_data.b) * MulW'(Recip);
  assign q_r    = prod_r[MulW-1:RecipShift];
  assign q_g    = prod_g[MulW-1:RecipShift];
  assign q_b    = prod_b[MulW-1:RecipShift];

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red   <= (q_r > QW'(ChanMax)) ? ChanMax : q_r[ChanW-1:0];
      green <= (q_g > QW'(ChanMax)) ? ChanMax : q_g[ChanW-1:0];
      blue  <= (q_b > QW'(ChanMax)) ? ChanMax : q_b[ChanW-1:0];
    end
  end

endmodule

>>> sv/hsv2rgb_checker.sv
`include "assert_macros.svh"

module hsv2rgb_checker import hsv2rgb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [HueW-1:0]  hue,
  input logic [PctW-1:0]  saturation,
  input logic [PctW-1:0]  brightness,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ChanW-1:0] red,
  input logic [ChanW-1:0] green,
  input logic [ChanW-1:0] blue
);

  logic out_stall;
  logic in_stall;

  assign out_stall = out_valid && !out_ready;
  assign in_stall  = in_valid && !in_ready;

  // Reset empties the pipe: no result and room for a request.
  `ASSERT_ANY(a_rst_empty, rst |=> !out_valid && in_ready)

  // Input stalls only when every stage is full behind a held result.
  `ASSERT_CLK(a_stall_full, !in_ready |-> out_stall)

  // A waiting request stays valid with its payload unchanged.
  `ASSERT_CLK(a_in_hold, in_stall |=> in_valid && $stable(hue) && $stable(saturation) && $stable(brightness))

  // A held result stays valid.
  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid)

  // A held result keeps its value.
  `ASSERT_CLK(a_out_stable, out_stall |=> $stable(red) && $stable(green) && $stable(blue))

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb import hsv2rgb_pkg::*;;

  localparam longint unsigned Denom     = 64'd38400000;
  localparam int              NumCorner = 21;
  localparam int              NumRandom = 1630;
  localparam int              ShowLimit = 10;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [PctW-1:0]  sat;
    logic [PctW-1:0]  val;
    logic             known;
    rgb_t             rgb;
  } pixel_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [HueW-1:0]  hue;
  logic [PctW-1:0]  saturation;
  logic [PctW-1:0]  brightness;
  logic             out_valid;
  logic             out_ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  rgb_t       expected_rgb_q[$];
  int         mismatch_count;
  int         stray_count;
  int         ready_mode;
  pixel_row_t corner_pixels [NumCorner];

  hsv_to_rgb_converter u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #10 clk = ~clk;

  // Scale a numerator over the common denominator down to one channel byte
  function automatic logic [ChanW-1:0] scale_to_byte(input longint unsigned num);
    longint unsigned q;
    q = (num * longint'(ChanMax)) / Denom;
    return (q > longint'(ChanMax)) ? ChanMax : q[ChanW-1:0];
  endfunction

  // Exact integer HSV to RGB conversion of one pixel
  function automatic rgb_t predict_rgb(input logic [HueW-1:0] h,
                                       input logic [PctW-1:0] s_in,
                                       input logic [PctW-1:0] v_in);
    longint unsigned s, v, t, f, mm, cm, xm, hs, hp, pm;
    sector_t sec;
    rgb_t res;
    hs = longint'(HueSector);
    hp = longint'(HuePair);
    pm = longint'(PctMax);
    s = (longint'(s_in) > pm) ? pm : longint'(s_in);
    v = (longint'(v_in) > pm) ? pm : longint'(v_in);
    // fold hue into a triangle over two sectors
    t = longint'(h) % hp;
    f = (t >= hs) ? (hp - t) : t;
    mm = hs * v * (pm - s);
    cm = hs * pm * v;
    xm = s * v * f + mm;
    // hue past the last sector stays in the last sector
    sec = (longint'(h) / hs > 5) ? SEC_MAG_RED : sector_t'(longint'(h) / hs);
    case (sec)
      SEC_RED_YEL: res = '{scale_to_byte(cm), scale_to_byte(xm), scale_to_byte(mm)};
      SEC_YEL_GRN: res = '{scale_to_byte(xm), scale_to_byte(cm), scale_to_byte(mm)};
      SEC_GRN_CYN: res = '{scale_to_byte(mm), scale_to_byte(cm), scale_to_byte(xm)};
      SEC_CYN_BLU: res = '{scale_to_byte(mm), scale_to_byte(xm), scale_to_byte(cm)};
      SEC_BLU_MAG: res = '{scale_to_byte(xm), scale_to_byte(mm), scale_to_byte(cm)};
      default:     res = '{scale_to_byte(cm), scale_to_byte(mm), scale_to_byte(xm)};
    endcase
    return res;
  endfunction

  // Present one request from a falling edge, hold until accepted, log the expectation
  task automatic send_pixel(input logic [HueW-1:0] h, input logic [PctW-1:0] s,
                            input logic [PctW-1:0] v, input rgb_t want);
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (!in_ready);
    expected_rgb_q.push_back(want);
    @(negedge clk);
  endtask

  // Hold off the sender for a number of cycles, with junk on the payload
  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    for (int k = 0; k < cycles; k++) begin
      hue        <= HueW'($urandom);
      saturation <= PctW'($urandom);
      brightness <= PctW'($urandom);
      @(negedge clk);
    end
  endtask

  // Hold off the sender until every outstanding request has come back
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_rgb_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [PctW-1:0] pick_percent();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 2) return PctW'($urandom_range(101, 127));
    if (sel == 2) return (($urandom & 1) != 0) ? PctMax : '0;
    return PctW'($urandom_range(0, 100));
  endfunction

  function automatic logic [HueW-1:0] pick_hue();
    int sel;
    int base;
    sel = $urandom_range(0, 9);
    if (sel == 0) return HueW'($urandom_range(23040, 32767));
    if (sel == 1) begin
      // land on or next to a sector boundary
      base = int'(HueSector) * int'($urandom_range(0, 6));
      return HueW'(base + int'($urandom_range(0, 2)) - ((base > 0) ? 1 : 0));
    end
    return HueW'($urandom_range(0, 23039));
  endfunction

  // Receiver: stall on a pattern that changes mode from time to time
  initial begin
    int mode_left;
    logic [7:0] ring;
    out_ready  = 1'b0;
    ready_mode = 0;
    mode_left  = 0;
    ring       = 8'b1011_0010;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 300);
      end
      mode_left--;
      ring = {ring[6:0], ring[7]};
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ring[0];
      endcase
    end
  end

  // Check each returned pixel against the oldest expectation
  initial begin
    rgb_t want;
    mismatch_count = 0;
    stray_count    = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_rgb_q.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= ShowLimit)
            $display("unexpected pixel r=%0d g=%0d b=%0d", red, green, blue);
        end else begin
          want = expected_rgb_q.pop_front();
          if (want.r !== red || want.g !== green || want.b !== blue) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= ShowLimit)
              $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.r, want.g, want.b, red, green, blue);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int burst_left;
    logic [HueW-1:0] h;
    logic [PctW-1:0] s, v;
    rgb_t want;

    corner_pixels = '{
      '{15'd0,     7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{15'd0,     7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{15'd0,     7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd3840,  7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{15'd7680,  7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},
      '{15'd11520, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},
      '{15'd15360, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{15'd19200, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
      '{15'd23039, 7'd100, 7'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd23040, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd32767, 7'd127, 7'd127, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd32767, 7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{15'd0,     7'd127, 7'd127, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd21000, 7'd100, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{15'd1920,  7'd50,  7'd50,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd5000,  7'd127, 7'd60,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd12345, 7'd101, 7'd101, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd16383, 7'd85,  7'd42,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd9999,  7'd1,   7'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd27000, 7'd64,  7'd99,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd7679,  7'd100, 7'd100, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    rst        = 1'b1;
    in_valid   = 1'b0;
    hue        = '0;
    saturation = '0;
    brightness = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // walk the corner cases back to back
    foreach (corner_pixels[i]) begin
      want = corner_pixels[i].known ? corner_pixels[i].rgb
           : predict_rgb(corner_pixels[i].hue, corner_pixels[i].sat, corner_pixels[i].val);
      send_pixel(corner_pixels[i].hue, corner_pixels[i].sat, corner_pixels[i].val, want);
    end
    drain_pipe();

    // random pixels: a gapless stretch first, then bursts with gaps
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < NumRandom; i++) begin
      h = pick_hue();
      s = pick_percent();
      v = pick_percent();
      send_pixel(h, s, v, predict_rgb(h, s, v));
      if (i == NumRandom / 2) begin
        drain_pipe();
      end else if (i >= 200) begin
        burst_left--;
        if (burst_left == 0) begin
          idle_sender($urandom_range(1, 15));
          burst_left = $urandom_range(1, 40);
        end
      end
    end
    in_valid <= 1'b0;

    // wait out the pipe, then give stray results time to show
    while (expected_rgb_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && stray_count == 0 && expected_rgb_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
